>>> rtl/core/tsgd_pkg.sv
package tsgd_pkg;

  // Fixed sizes
  localparam int SeqDepth      = 8;
  localparam int SeqIdxW       = $clog2(SeqDepth);
  localparam int PadCountDef   = 10;
  localparam int PadW          = 4;
  localparam int CfgIdxW       = 3;
  localparam int QueueDepthDef = 2;

  // Change counts with special meaning
  localparam logic [SeqIdxW:0] NoEndCount  = (SeqIdxW + 1)'(7);
  localparam logic [SeqIdxW:0] FullCount   = (SeqIdxW + 1)'(SeqDepth);
  localparam logic [SeqIdxW:0] SelectCntLo = (SeqIdxW + 1)'(2);
  localparam logic [SeqIdxW:0] SelectCntHi = (SeqIdxW + 1)'(3);

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_PAD_FIRST  = 3'd0,
    CFG_PAD_SECOND = 3'd1,
    CFG_PAD_THIRD  = 3'd2,
    CFG_PAD_FOURTH = 3'd3
  } cfg_idx_e;

  // Reset values of the pad registers
  localparam logic [PadW-1:0] PadFirstRst  = 4'd5;
  localparam logic [PadW-1:0] PadSecondRst = 4'd4;
  localparam logic [PadW-1:0] PadThirdRst  = 4'd7;
  localparam logic [PadW-1:0] PadFourthRst = 4'd8;

  typedef struct packed {
    logic [PadW-1:0] first;
    logic [PadW-1:0] second;
    logic [PadW-1:0] third;
    logic [PadW-1:0] fourth;
  } pads_t;

  // Classification of one beat, passed from front to back
  typedef struct packed {
    logic sel;
    logic done;
  } flags_t;

endpackage

>>> rtl/core/touch_slide_gesture_detector.sv
// Touch slide gesture detector.
// Input channel: one pad status bitmask per beat (in_valid_i/in_ready_o).
// Output channel: one result beat per input beat (out_valid_o/out_ready_i)
// carrying select, right slide, left slide and gesture-done flags.
// Config channel: cfg_valid_i/cfg_ready_o, index 0..3 selects the first,
// second, third and fourth slider pad; other indexes are ignored. Write
// only while no beat is in flight. cfg_ready_o is always high.
// Path: an accepted beat enters the queue, then moves to the output register
// when that register is free or being drained; its result waits there to be taken.
// Throughput: one beat per cycle while the queue is not full; the front
// updates the change record and the back does the full 8-entry pattern compare.
// A two-entry queue sits between front and back, so a stalled receiver
// still lets up to two more beats in; after that in_ready_o drops until
// results are drained.
// Reset: pad registers return to 5, 4, 7, 8; last status, change count and
// all record entries clear to zero; no result is pending.
module touch_slide_gesture_detector
  import tsgd_pkg::*;
#(
  parameter int PAD_COUNT   = PadCountDef,
  parameter int QUEUE_DEPTH = QueueDepthDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [PAD_COUNT-1:0] pad_status_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 select_seen_o,
  output logic                 right_seen_o,
  output logic                 left_seen_o,
  output logic                 gesture_done_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIdxW-1:0]   cfg_index_i,
  input  logic [PadW-1:0]      cfg_data_i
);

  localparam int RecW = SeqDepth * PAD_COUNT;
  localparam int QW   = $bits(flags_t) + RecW;

  pads_t              pads_q;
  logic               accept;
  logic               q_full, q_empty, q_pop;
  flags_t             front_flags, back_flags;
  logic [RecW-1:0]    front_rec, back_rec;
  logic [QW-1:0]      q_out;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pads_q.first  <= PadFirstRst;
      pads_q.second <= PadSecondRst;
      pads_q.third  <= PadThirdRst;
      pads_q.fourth <= PadFourthRst;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_PAD_FIRST:  pads_q.first  <= cfg_data_i;
        CFG_PAD_SECOND: pads_q.second <= cfg_data_i;
        CFG_PAD_THIRD:  pads_q.third  <= cfg_data_i;
        CFG_PAD_FOURTH: pads_q.fourth <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_ready_o = !q_full;
  assign accept     = in_valid_i && in_ready_o;

  tsgd_front #(
    .PAD_COUNT(PAD_COUNT)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .status_i (pad_status_i),
    .flags_o  (front_flags),
    .record_o (front_rec)
  );

  tsgd_queue #(
    .WIDTH(QW),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .push_data_i ({front_flags, front_rec}),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .empty_o     (q_empty),
    .pop_data_o  (q_out)
  );

  assign back_flags = q_out[QW-1:RecW];
  assign back_rec   = q_out[RecW-1:0];

  tsgd_back #(
    .PAD_COUNT(PAD_COUNT)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .pads_i         (pads_q),
    .empty_i        (q_empty),
    .flags_i        (back_flags),
    .record_i       (back_rec),
    .pop_o          (q_pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .select_seen_o  (select_seen_o),
    .right_seen_o   (right_seen_o),
    .left_seen_o    (left_seen_o),
    .gesture_done_o (gesture_done_o)
  );

`ifndef SYNTHESIS
  // A select always ends a gesture
  a_sel_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && select_seen_o) |-> gesture_done_o)
    else $error("select without gesture end");

  // Slide flags only on a gesture end
  a_slide_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (right_seen_o || left_seen_o)) |-> gesture_done_o)
    else $error("slide flag without gesture end");

  // Input backpressure only comes from a stalled output
  a_bp_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !q_empty))
    else $error("input stalled with idle output");

  // An accepted beat passes through the queue and the output register when the path is idle
  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && q_empty && !out_valid_o) |=> ##1 out_valid_o)
    else $error("result missing two cycles after accept");
`endif

endmodule

>>> rtl/core/tsgd_front.sv
module tsgd_front
  import tsgd_pkg::*;
#(
  parameter int PAD_COUNT = PadCountDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic [PAD_COUNT-1:0]          status_i,
  output flags_t                        flags_o,
  output logic [SeqDepth*PAD_COUNT-1:0] record_o
);

  logic [PAD_COUNT-1:0] last_q, last_d;
  logic [SeqIdxW-1:0]   count_q, count_d;
  logic [PAD_COUNT-1:0] rec_q [SeqDepth];
  logic [PAD_COUNT-1:0] rec_d [SeqDepth];

  logic                 changed;
  logic                 release_end;
  logic [SeqIdxW:0]     cnt_inc;
  logic                 end_gesture;

  // Change detection and gesture end
  always_comb begin
    changed     = (status_i != last_q);
    cnt_inc     = {1'b0, count_q} + (SeqIdxW + 1)'(1);
    release_end = changed && (status_i == '0) && (cnt_inc != NoEndCount);
    end_gesture = release_end || (changed && (cnt_inc == FullCount));
    flags_o.sel  = release_end && (cnt_inc inside {SelectCntLo, SelectCntHi});
    flags_o.done = end_gesture;
  end

  // Next state: record write at the current count
  always_comb begin
    rec_d   = rec_q;
    last_d  = last_q;
    count_d = count_q;
    if (changed) begin
      rec_d[count_q] = status_i;
      last_d         = status_i;
      count_d        = end_gesture ? '0 : cnt_inc[SeqIdxW-1:0];
    end
  end

  // Record snapshot including this beat's write
  always_comb begin
    for (int k = 0; k < SeqDepth; k++) begin
      record_o[k*PAD_COUNT +: PAD_COUNT] = rec_d[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q  <= '0;
      count_q <= '0;
      for (int k = 0; k < SeqDepth; k++) begin
        rec_q[k] <= '0;
      end
    end else if (accept_i) begin
      last_q  <= last_d;
      count_q <= count_d;
      rec_q   <= rec_d;
    end
  end

endmodule

>>> rtl/core/tsgd_queue.sv
module tsgd_queue
  import tsgd_pkg::*;
#(
  parameter int WIDTH = 2,
  parameter int DEPTH = QueueDepthDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_push, do_pop;

  assign full_o     = (cnt_q == CntW'(DEPTH));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;

  // Storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

>>> rtl/core/tsgd_back.sv
module tsgd_back
  import tsgd_pkg::*;
#(
  parameter int PAD_COUNT = PadCountDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pads_t                         pads_i,
  input  logic                          empty_i,
  input  flags_t                        flags_i,
  input  logic [SeqDepth*PAD_COUNT-1:0] record_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          select_seen_o,
  output logic                          right_seen_o,
  output logic                          left_seen_o,
  output logic                          gesture_done_o
);

  function automatic logic [PAD_COUNT-1:0] onehot(input logic [PadW-1:0] pad);
    onehot = {{(PAD_COUNT-1){1'b0}}, 1'b1} << pad;
  endfunction

  logic                 valid_q;
  logic                 sel_q, right_q, left_q, done_q;
  logic                 pads_ok;
  logic [PAD_COUNT-1:0] p1, p2, p3, p4;
  logic [PAD_COUNT-1:0] rpat [SeqDepth];
  logic [PAD_COUNT-1:0] lpat [SeqDepth];
  logic                 right_match, left_match;

  // Pop when the output register is free or being drained
  assign pop_o = !empty_i && (!valid_q || out_ready_i);

  // Slide patterns from the four pad registers
  always_comb begin
    pads_ok = (int'(pads_i.first) < PAD_COUNT) && (int'(pads_i.second) < PAD_COUNT) &&
              (int'(pads_i.third) < PAD_COUNT) && (int'(pads_i.fourth) < PAD_COUNT);
    p1 = onehot(pads_i.first);
    p2 = onehot(pads_i.second);
    p3 = onehot(pads_i.third);
    p4 = onehot(pads_i.fourth);
    rpat[0] = p1;      rpat[1] = p1 | p2; rpat[2] = p2;      rpat[3] = p2 | p3;
    rpat[4] = p3;      rpat[5] = p3 | p4; rpat[6] = p4;      rpat[7] = '0;
    lpat[0] = p4;      lpat[1] = p4 | p3; lpat[2] = p3;      lpat[3] = p3 | p2;
    lpat[4] = p2;      lpat[5] = p2 | p1; lpat[6] = p1;      lpat[7] = '0;
  end

  // Parallel compare of the whole record
  always_comb begin
    right_match = pads_ok;
    left_match  = pads_ok;
    for (int k = 0; k < SeqDepth; k++) begin
      if (record_i[k*PAD_COUNT +: PAD_COUNT] != rpat[k]) right_match = 1'b0;
      if (record_i[k*PAD_COUNT +: PAD_COUNT] != lpat[k]) left_match = 1'b0;
    end
  end

  // Output register, payload
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      sel_q   <= flags_i.sel;
      done_q  <= flags_i.done;
      right_q <= flags_i.done && right_match;
      left_q  <= flags_i.done && left_match;
    end
  end

  // Output register, valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  assign out_valid_o    = valid_q;
  assign select_seen_o  = sel_q;
  assign right_seen_o   = right_q;
  assign left_seen_o    = left_q;
  assign gesture_done_o = done_q;

endmodule
